[rtl/core/http_chunked_encoder_assert.svh]
// ----------------------------------------------------------------------------
// http chunked encoder assertion macros
// shared property shapes for the checker, clocked on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_ENCODER_ASSERT_SVH
`define HTTP_CHUNKED_ENCODER_ASSERT_SVH

// same-cycle implication
`define HCE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hce assertion failed");

// next-cycle implication
`define HCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hce assertion failed");

`endif

[rtl/core/hce_pkg.sv]
// ----------------------------------------------------------------------------
// hce_pkg
// types and constants shared by the chunked transfer encoder
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int BUFFER_DEPTH = 32;

  localparam logic [5:0] LIMIT_RESET = 6'd32;

  localparam logic [7:0] ASCII_CR   = 8'h0D;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_FINISH = 2'd2,
    OP_CLOSE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEX_HI,
    ST_HEX_LO,
    ST_CR1,
    ST_LF1,
    ST_DATA,
    ST_CR2,
    ST_LF2,
    ST_ZERO,
    ST_CR3,
    ST_LF3,
    ST_CR4,
    ST_LF4,
    ST_ERR
  } state_t;

  typedef logic [5:0] limit_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       write_error;
  } out_item_t;

  // buffer control from the sequencer to the cell row
  typedef struct packed {
    logic       wr;
    logic       shift;
    logic [5:0] wr_idx;
    logic [7:0] wr_byte;
  } buf_ctl_t;

endpackage

[rtl/core/hce_chan_if.sv]
// ----------------------------------------------------------------------------
// hce_chan_if
// valid/ready channel carrying one payload of type T
// ----------------------------------------------------------------------------
interface hce_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/hce_cell.sv]
// ----------------------------------------------------------------------------
// hce_cell
// one byte of the chunk buffer: loads a new byte or takes its neighbour's
// ----------------------------------------------------------------------------
module hce_cell (
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic [7:0] load_byte,
  input  logic [7:0] next_byte,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_byte;
    end else if (shift) begin
      q <= next_byte;
    end
  end

endmodule

[rtl/core/hce_ctrl.sv]
// ----------------------------------------------------------------------------
// hce_ctrl
// request decode, framing sequencer and output register of the encoder
// ----------------------------------------------------------------------------
module hce_ctrl #(
  parameter int BUFFER_DEPTH = hce_pkg::BUFFER_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  hce_chan_if.sink            item,
  hce_chan_if.source          result,
  hce_chan_if.sink            cfg,
  input  logic [7:0]          head_byte,
  output hce_pkg::buf_ctl_t   buf_ctl
);

  localparam logic [5:0] DEPTH_W = 6'(BUFFER_DEPTH);

  hce_pkg::state_t state, state_next;
  logic [5:0]      fill;
  logic            final_sent;
  logic            closed;
  logic            with_final;
  hce_pkg::limit_t chunk_limit;

  logic            out_valid;
  hce_pkg::out_item_t out_data;

  logic            out_free;
  logic            fire;
  logic            emit;
  logic [5:0]      lim;
  logic [5:0]      fill_inc;
  logic            wr_ok;
  logic            start_final;
  hce_pkg::out_item_t emit_data;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
  endfunction

  assign out_free = !out_valid || result.ready;
  assign fire     = item.valid && item.ready;
  assign fill_inc = fill + 6'd1;
  assign wr_ok    = (item.data.op == hce_pkg::OP_WRITE) && !closed;

  // clamp the limit into 1 .. depth
  always_comb begin
    if (chunk_limit == 6'd0) begin
      lim = 6'd1;
    end else if (chunk_limit > DEPTH_W) begin
      lim = DEPTH_W;
    end else begin
      lim = chunk_limit;
    end
  end

  // finish or close that still owes the closing chunk
  always_comb begin
    start_final = 1'b0;
    if (item.data.op == hce_pkg::OP_FINISH) begin
      start_final = !final_sent;
    end else if (item.data.op == hce_pkg::OP_CLOSE) begin
      start_final = !closed && !final_sent;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hce_pkg::ST_IDLE: begin
        if (fire) begin
          unique case (item.data.op)
            hce_pkg::OP_WRITE: begin
              if (closed) begin
                state_next = hce_pkg::ST_ERR;
              end else if (fill_inc >= lim) begin
                state_next = (fill_inc[5:4] != 2'd0) ? hce_pkg::ST_HEX_HI
                                                     : hce_pkg::ST_HEX_LO;
              end
            end
            hce_pkg::OP_FLUSH: begin
              if (fill != 6'd0) begin
                state_next = (fill[5:4] != 2'd0) ? hce_pkg::ST_HEX_HI
                                                 : hce_pkg::ST_HEX_LO;
              end
            end
            hce_pkg::OP_FINISH, hce_pkg::OP_CLOSE: begin
              if (start_final) begin
                if (fill == 6'd0) begin
                  state_next = hce_pkg::ST_ZERO;
                end else begin
                  state_next = (fill[5:4] != 2'd0) ? hce_pkg::ST_HEX_HI
                                                   : hce_pkg::ST_HEX_LO;
                end
              end
            end
            default: state_next = state;
          endcase
        end
      end
      hce_pkg::ST_HEX_HI: if (out_free) state_next = hce_pkg::ST_HEX_LO;
      hce_pkg::ST_HEX_LO: if (out_free) state_next = hce_pkg::ST_CR1;
      hce_pkg::ST_CR1:    if (out_free) state_next = hce_pkg::ST_LF1;
      hce_pkg::ST_LF1:    if (out_free) state_next = hce_pkg::ST_DATA;
      hce_pkg::ST_DATA: begin
        if (out_free && fill == 6'd1) begin
          state_next = hce_pkg::ST_CR2;
        end
      end
      hce_pkg::ST_CR2:    if (out_free) state_next = hce_pkg::ST_LF2;
      hce_pkg::ST_LF2: begin
        if (out_free) begin
          state_next = with_final ? hce_pkg::ST_ZERO : hce_pkg::ST_IDLE;
        end
      end
      hce_pkg::ST_ZERO:   if (out_free) state_next = hce_pkg::ST_CR3;
      hce_pkg::ST_CR3:    if (out_free) state_next = hce_pkg::ST_LF3;
      hce_pkg::ST_LF3:    if (out_free) state_next = hce_pkg::ST_CR4;
      hce_pkg::ST_CR4:    if (out_free) state_next = hce_pkg::ST_LF4;
      hce_pkg::ST_LF4:    if (out_free) state_next = hce_pkg::ST_IDLE;
      hce_pkg::ST_ERR:    if (out_free) state_next = hce_pkg::ST_IDLE;
      default:            state_next = hce_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit_data   = '0;
    item.ready  = (state == hce_pkg::ST_IDLE);
    emit        = (state != hce_pkg::ST_IDLE) && out_free;
    unique case (state)
      hce_pkg::ST_IDLE:   emit_data.out_byte = 8'h00;
      hce_pkg::ST_HEX_HI: emit_data.out_byte = hex_char({2'b00, fill[5:4]});
      hce_pkg::ST_HEX_LO: emit_data.out_byte = hex_char(fill[3:0]);
      hce_pkg::ST_CR1, hce_pkg::ST_CR2, hce_pkg::ST_CR3, hce_pkg::ST_CR4: begin
        emit_data.out_byte = hce_pkg::ASCII_CR;
      end
      hce_pkg::ST_LF1, hce_pkg::ST_LF3: emit_data.out_byte = hce_pkg::ASCII_LF;
      hce_pkg::ST_DATA:   emit_data.out_byte = head_byte;
      hce_pkg::ST_LF2: begin
        emit_data.out_byte = hce_pkg::ASCII_LF;
        emit_data.last     = !with_final;
      end
      hce_pkg::ST_ZERO:   emit_data.out_byte = hce_pkg::ASCII_ZERO;
      hce_pkg::ST_LF4: begin
        emit_data.out_byte = hce_pkg::ASCII_LF;
        emit_data.last     = 1'b1;
      end
      hce_pkg::ST_ERR: begin
        emit_data.last        = 1'b1;
        emit_data.write_error = 1'b1;
      end
      default:            emit_data.out_byte = 8'h00;
    endcase
  end

  assign buf_ctl.wr      = fire && wr_ok;
  assign buf_ctl.shift   = (state == hce_pkg::ST_DATA) && out_free;
  assign buf_ctl.wr_idx  = fill;
  assign buf_ctl.wr_byte = item.data.data_byte;

  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hce_pkg::ST_IDLE;
      fill        <= 6'd0;
      final_sent  <= 1'b0;
      closed      <= 1'b0;
      with_final  <= 1'b0;
      chunk_limit <= hce_pkg::LIMIT_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        chunk_limit <= cfg.data;
      end
      if (fire) begin
        with_final <= (item.data.op == hce_pkg::OP_FINISH) ||
                      (item.data.op == hce_pkg::OP_CLOSE);
        if (wr_ok) begin
          fill <= fill_inc;
        end
        if (start_final) begin
          final_sent <= 1'b1;
        end
        if (item.data.op == hce_pkg::OP_CLOSE) begin
          closed <= 1'b1;
        end
      end else if (buf_ctl.shift) begin
        fill <= fill - 6'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_data;
    end
  end

endmodule

[rtl/core/http_chunked_encoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_encoder
// http/1.1 chunked transfer encoder over a row of byte cells
// ----------------------------------------------------------------------------
// A write request that does not fill the chunk stores its byte and sends nothing. A
// request that sends a chunk of n payload bytes holds the input while the
// block puts out one or two hex digits, two CR LF pairs and the bytes, and a
// closing chunk adds five more bytes; the output register hands out one byte
// per cycle while result.ready does not stall it. The buffer is a row of
// cells that drains towards cell 0 one byte per output cycle; new bytes land
// in the cell at the current fill position. No request is taken while a
// chunk is being sent. The chunk limit register may be written at any time
// the block is idle and applies from the next request on.
module http_chunked_encoder #(
  parameter int BUFFER_DEPTH = hce_pkg::BUFFER_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  hce_chan_if.sink    item,
  hce_chan_if.source  result,
  hce_chan_if.sink    cfg
);

  hce_pkg::buf_ctl_t buf_ctl;
  logic [7:0]        cell_q [BUFFER_DEPTH];

  hce_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg       (cfg),
    .head_byte (cell_q[0]),
    .buf_ctl   (buf_ctl)
  );

  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    logic       load;
    logic [7:0] next_byte;

    assign load = buf_ctl.wr && (buf_ctl.wr_idx == 6'(i));

    if (i == BUFFER_DEPTH - 1) begin : g_tail
      assign next_byte = 8'h00;
    end else begin : g_body
      assign next_byte = cell_q[i + 1];
    end

    hce_cell u_cell (
      .clk       (clk),
      .load      (load),
      .shift     (buf_ctl.shift),
      .load_byte (buf_ctl.wr_byte),
      .next_byte (next_byte),
      .q         (cell_q[i])
    );
  end

endmodule

[rtl/core/hce_checker.sv]
// ----------------------------------------------------------------------------
// hce_checker
// port-level checks of the chunked encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "http_chunked_encoder_assert.svh"

module hce_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] out_byte,
  input logic       last,
  input logic       write_error
);

  logic [9:0] res_word;

  assign res_word = {out_byte, last, write_error};

  // a stalled result keeps its value
  `HCE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(res_word))

  // the error result carries no byte and ends its request
  `HCE_ASSERT_IMPL(a_error_shape, result_valid && write_error, last && (out_byte == 8'h00))

  // every chunk sequence ends on line feed
  `HCE_ASSERT_IMPL(a_last_is_lf, result_valid && last && !write_error, out_byte == hce_pkg::ASCII_LF)

  // no new request while a sequence is still being sent
  `HCE_ASSERT_IMPL(a_busy_mid_seq, result_valid && !last, !item_ready)

endmodule

bind http_chunked_encoder hce_checker u_hce_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .out_byte     (result.data.out_byte),
  .last         (result.data.last),
  .write_error  (result.data.write_error)
);
